// ===== src/wavhp_pkg.sv =====
`default_nettype none
package wavhp_pkg;

  // Chunk ids as read little-endian from the byte stream
  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  // Byte counts of the fixed header parts and the byte index saturation value
  localparam logic [4:0] ID_BYTES      = 5'd4;
  localparam logic [4:0] RIFF_BODY_BYTES = 5'd8;
  localparam logic [4:0] IDX_SAT       = 5'd16;
  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;

  typedef enum logic [2:0] {
    PH_ID        = 3'd0,
    PH_RIFF_BODY = 3'd1,
    PH_FMT_SIZE  = 3'd2,
    PH_FMT_BODY  = 3'd3,
    PH_DATA_SIZE = 3'd4,
    PH_STOPPED   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNKNOWN   = 2'd1,
    ST_NO_FMT    = 2'd2,
    ST_FMT_SHORT = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] rate_hz;
    logic [15:0] chan_num;
    logic [15:0] samp_bits;
    logic [31:0] data_size;
    logic [31:0] data_offset;
  } out_word_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_push_t;

endpackage
`default_nettype wire

// ===== src/wavhp_core.sv =====
`default_nettype none
module wavhp_core
  import wavhp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  input  wire logic      res_ready_i,
  output res_push_t      res_o
);

  logic     in_vld_q;
  in_word_t in_word_q;
  logic     fire;

  phase_e      phase_q, phase_d, phase_c;
  logic [31:0] id_q, id_d, id_c, id_new;
  logic [31:0] len_q, len_d, len_c;
  logic [31:0] left_q, left_d, left_c;
  logic [4:0]  idx_q, idx_d, idx_c, idx_inc;
  logic [31:0] pos_q, pos_d;
  logic [31:0] rate_q, rate_d, rate_c;
  logic [15:0] ch_q, ch_d, ch_c;
  logic [15:0] bits_q, bits_d, bits_c;
  logic        seen_q, seen_d, seen_c;
  logic [7:0]  b;

  // Hold the input word while the result side is full
  assign in_stall_o = in_vld_q & ~res_ready_i;
  assign fire       = in_vld_q & res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_word_q <= in_word_i;
    end
  end

  // Parse one byte: restart on a first-byte mark, then step the phase
  always_comb begin
    b = in_word_q.byte_value;
    if (in_word_q.first_byte) begin
      phase_c = PH_ID;
      id_c    = '0;
      len_c   = '0;
      left_c  = '0;
      idx_c   = '0;
      pos_d   = 32'd1;
      rate_c  = '0;
      ch_c    = '0;
      bits_c  = '0;
      seen_c  = 1'b0;
    end else begin
      phase_c = phase_q;
      id_c    = id_q;
      len_c   = len_q;
      left_c  = left_q;
      idx_c   = idx_q;
      pos_d   = pos_q + 32'd1;
      rate_c  = rate_q;
      ch_c    = ch_q;
      bits_c  = bits_q;
      seen_c  = seen_q;
    end

    id_new  = {b, id_c[31:8]};
    idx_inc = (idx_c == IDX_SAT) ? idx_c : idx_c + 5'd1;

    phase_d = phase_c;
    id_d    = id_c;
    len_d   = len_c;
    left_d  = left_c;
    idx_d   = idx_c;
    rate_d  = rate_c;
    ch_d    = ch_c;
    bits_d  = bits_c;
    seen_d  = seen_c;

    res_o = '0;

    case (phase_c)
      PH_ID: begin
        id_d  = id_new;
        idx_d = idx_inc;
        if (idx_inc == ID_BYTES) begin
          idx_d = '0;
          if (id_new == ID_RIFF) begin
            phase_d = PH_RIFF_BODY;
          end else if (id_new == ID_FMT) begin
            phase_d = PH_FMT_SIZE;
          end else if (id_new == ID_DATA) begin
            phase_d = PH_DATA_SIZE;
          end else begin
            res_o.valid       = 1'b1;
            res_o.word.status = ST_UNKNOWN;
            phase_d           = PH_STOPPED;
          end
        end
      end
      PH_RIFF_BODY: begin
        idx_d = idx_inc;
        if (idx_inc == RIFF_BODY_BYTES) begin
          idx_d   = '0;
          phase_d = PH_ID;
        end
      end
      PH_FMT_SIZE: begin
        id_d  = id_new;
        idx_d = idx_inc;
        if (idx_inc == ID_BYTES) begin
          idx_d = '0;
          len_d = id_new;
          if (id_new < FMT_MIN_SIZE) begin
            res_o.valid       = 1'b1;
            res_o.word.status = ST_FMT_SHORT;
            phase_d           = PH_STOPPED;
          end else begin
            left_d  = id_new;
            phase_d = PH_FMT_BODY;
          end
        end
      end
      PH_FMT_BODY: begin
        // Capture the format fields at their body offsets
        case (idx_c)
          5'd2:  ch_d[7:0]    = b;
          5'd3:  ch_d[15:8]   = b;
          5'd4:  rate_d[7:0]  = b;
          5'd5:  rate_d[15:8] = b;
          5'd6:  rate_d[23:16] = b;
          5'd7:  rate_d[31:24] = b;
          5'd14: bits_d[7:0]  = b;
          5'd15: bits_d[15:8] = b;
          default: ;
        endcase
        idx_d  = idx_inc;
        left_d = left_c - 32'd1;
        if (left_c == 32'd1) begin
          idx_d   = '0;
          seen_d  = 1'b1;
          phase_d = PH_ID;
        end
      end
      PH_DATA_SIZE: begin
        id_d  = id_new;
        idx_d = idx_inc;
        if (idx_inc == ID_BYTES) begin
          idx_d       = '0;
          len_d       = id_new;
          res_o.valid = 1'b1;
          phase_d     = PH_STOPPED;
          if (seen_c) begin
            res_o.word.status      = ST_OK;
            res_o.word.rate_hz     = rate_c;
            res_o.word.chan_num    = ch_c;
            res_o.word.samp_bits   = bits_c;
            res_o.word.data_size   = id_new;
            res_o.word.data_offset = pos_d;
          end else begin
            res_o.word.status = ST_NO_FMT;
          end
        end
      end
      default: ;
    endcase

    if (!fire) begin
      res_o.valid = 1'b0;
    end
  end

  // Advance the parse state on each processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID;
      id_q    <= '0;
      len_q   <= '0;
      left_q  <= '0;
      idx_q   <= '0;
      pos_q   <= '0;
      rate_q  <= '0;
      ch_q    <= '0;
      bits_q  <= '0;
      seen_q  <= 1'b0;
    end else if (fire) begin
      phase_q <= phase_d;
      id_q    <= id_d;
      len_q   <= len_d;
      left_q  <= left_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
      rate_q  <= rate_d;
      ch_q    <= ch_d;
      bits_q  <= bits_d;
      seen_q  <= seen_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/wavhp_out_buf.sv =====
`default_nettype none
module wavhp_out_buf
  import wavhp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire res_push_t res_i,
  output logic           res_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  logic      out_vld_q;
  out_word_t out_q;
  logic      skid_vld_q;
  out_word_t skid_q;
  logic      pop;

  assign pop         = out_vld_q & ~out_stall_i;
  assign res_ready_o = ~skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  // Track occupancy of the result and skid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (res_i.valid) begin
      if (!out_vld_q || pop) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  // Move result words; refill from skid first
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (res_i.valid) begin
      if (!out_vld_q || pop) begin
        out_q <= res_i.word;
      end else begin
        skid_q <= res_i.word;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/wav_header_chunk_parser_top.sv =====
`default_nettype none
// WAV header parser. Takes one file byte per cycle unless stalled and walks
// the RIFF chunk ids; a "data" chunk ends the parse with one result word
// carrying format, data size and sample offset, or an error status (unknown
// id, data before fmt, short fmt). Sustained rate is one byte per cycle while
// the output is not stalled; an accepted byte sits in the input register and
// its result word is then registered in the result register.
// A skid register behind the result register lets input run on while a result
// waits; input stalls only when both are full. Bytes after a result are
// dropped until the next first_byte mark.
module wav_header_chunk_parser_top
  import wavhp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  res_push_t res;
  logic      res_ready;

  wavhp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  wavhp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire

// ===== tb/tb_wav_header_chunk_parser_top.sv =====
`timescale 1ns / 1ps
module tb_wav_header_chunk_parser_top
  import wavhp_pkg::*;
();

  localparam int          CYCLE_LIMIT   = 200_000;
  localparam int          DRAIN_LIMIT   = 4_000;
  localparam int          SETTLE_CYCLES = 6;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          TOTAL_BYTES   = 1950;
  localparam logic [31:0] ID_LIST       = 32'h5453_494C;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  wav_header_chunk_parser_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // Shared run state
  out_word_t header_results_q[$];
  int        errors        = 0;
  int        bytes_sent    = 0;
  int        hold_left     = 0;
  int        cycle_count   = 0;
  bit        calm          = 1'b0;
  bit        mark_pending  = 1'b0;

  // Parser state mirror
  phase_e      ph;
  logic [31:0] id_sh;
  logic [31:0] chunk_len;
  logic [31:0] body_left;
  logic [31:0] byte_idx;
  logic [31:0] file_pos;
  logic [31:0] rate_s;
  logic [15:0] chan_s;
  logic [15:0] bits_s;
  logic        fmt_seen;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic void clear_parse();
    ph        = PH_ID;
    id_sh     = '0;
    chunk_len = '0;
    body_left = '0;
    byte_idx  = '0;
    file_pos  = '0;
    rate_s    = '0;
    chan_s    = '0;
    bits_s    = '0;
    fmt_seen  = 1'b0;
  endfunction

  // Error words carry the status alone
  function automatic out_word_t header_result(input status_e st);
    out_word_t r;
    r        = '0;
    r.status = st;
    if (st == ST_OK) begin
      r.rate_hz     = rate_s;
      r.chan_num    = chan_s;
      r.samp_bits   = bits_s;
      r.data_size   = chunk_len;
      r.data_offset = file_pos;
    end
    return r;
  endfunction

  // Advance the parse by one byte; return 1 when a header result is due
  function automatic bit parse_header_byte(input logic [7:0] b, input logic first,
                                           output out_word_t r);
    bit got;
    got = 1'b0;
    r   = '0;
    if (first) clear_parse();
    file_pos = file_pos + 32'd1;
    case (ph)
      PH_ID: begin
        id_sh    = {b, id_sh[31:8]};
        byte_idx = byte_idx + 32'd1;
        if (byte_idx == 32'(ID_BYTES)) begin
          byte_idx = '0;
          if (id_sh == ID_RIFF) ph = PH_RIFF_BODY;
          else if (id_sh == ID_FMT) ph = PH_FMT_SIZE;
          else if (id_sh == ID_DATA) ph = PH_DATA_SIZE;
          else begin
            r   = header_result(ST_UNKNOWN);
            got = 1'b1;
            ph  = PH_STOPPED;
          end
        end
      end
      PH_RIFF_BODY: begin
        byte_idx = byte_idx + 32'd1;
        if (byte_idx == 32'(RIFF_BODY_BYTES)) begin
          byte_idx = '0;
          ph       = PH_ID;
        end
      end
      PH_FMT_SIZE: begin
        id_sh    = {b, id_sh[31:8]};
        byte_idx = byte_idx + 32'd1;
        if (byte_idx == 32'(ID_BYTES)) begin
          byte_idx  = '0;
          chunk_len = id_sh;
          if (chunk_len < FMT_MIN_SIZE) begin
            r   = header_result(ST_FMT_SHORT);
            got = 1'b1;
            ph  = PH_STOPPED;
          end else begin
            body_left = chunk_len;
            ph        = PH_FMT_BODY;
          end
        end
      end
      PH_FMT_BODY: begin
        case (byte_idx)
          32'd2:  chan_s[7:0]   = b;
          32'd3:  chan_s[15:8]  = b;
          32'd4:  rate_s[7:0]   = b;
          32'd5:  rate_s[15:8]  = b;
          32'd6:  rate_s[23:16] = b;
          32'd7:  rate_s[31:24] = b;
          32'd14: bits_s[7:0]   = b;
          32'd15: bits_s[15:8]  = b;
          default: ;
        endcase
        byte_idx  = byte_idx + 32'd1;
        body_left = body_left - 32'd1;
        if (body_left == '0) begin
          byte_idx = '0;
          fmt_seen = 1'b1;
          ph       = PH_ID;
        end
      end
      PH_DATA_SIZE: begin
        id_sh    = {b, id_sh[31:8]};
        byte_idx = byte_idx + 32'd1;
        if (byte_idx == 32'(ID_BYTES)) begin
          byte_idx  = '0;
          chunk_len = id_sh;
          r         = header_result(fmt_seen ? ST_OK : ST_NO_FMT);
          got       = 1'b1;
          ph        = PH_STOPPED;
        end
      end
      default: ;
    endcase
    return got;
  endfunction

  // Offer one word, hold it until accepted, then log the expected result
  task automatic put_byte(input logic [7:0] b);
    in_word_t  w;
    out_word_t r;
    if (!calm && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    w.byte_value = b;
    w.first_byte = mark_pending;
    in_valid_i  <= 1'b1;
    in_word_i   <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (parse_header_byte(b, w.first_byte, r)) header_results_q.push_back(r);
    mark_pending = 1'b0;
    bytes_sent++;
  endtask

  task automatic put_word(input logic [31:0] v);
    put_byte(v[7:0]);
    put_byte(v[15:8]);
    put_byte(v[23:16]);
    put_byte(v[31:24]);
  endtask

  task automatic put_riff();
    put_word(ID_RIFF);
    put_word($urandom);
    put_word($urandom);
  endtask

  // Send a fmt chunk id and size, then the first body_sent bytes of its body
  task automatic put_fmt(input logic [31:0] size, input int body_sent,
                         input logic [31:0] rate, input logic [31:0] chans,
                         input logic [31:0] bits);
    logic [7:0] bv;
    put_word(ID_FMT);
    put_word(size);
    for (int i = 0; i < body_sent; i++) begin
      case (i)
        2:       bv = chans[7:0];
        3:       bv = chans[15:8];
        4:       bv = rate[7:0];
        5:       bv = rate[15:8];
        6:       bv = rate[23:16];
        7:       bv = rate[31:24];
        14:      bv = bits[7:0];
        15:      bv = bits[15:8];
        default: bv = 8'($urandom);
      endcase
      put_byte(bv);
    end
  endtask

  // Drop valid and wait for every expected result, then let the pipe settle
  task automatic wait_results_drained();
    int waited;
    waited      = 0;
    in_valid_i <= 1'b0;
    while (header_results_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (header_results_q.size() == 0) begin
      $display("%0t: unexpected result word, expected none got %h", $time, got);
      errors++;
    end else begin
      want = header_results_q.pop_front();
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("rate_hz", want.rate_hz, got.rate_hz);
      check_field("chan_num", 32'(want.chan_num), 32'(got.chan_num));
      check_field("samp_bits", 32'(want.samp_bits), 32'(got.samp_bits));
      check_field("data_size", want.data_size, got.data_size);
      check_field("data_offset", want.data_offset, got.data_offset);
    end
  endtask

  // Output side: check accepted words, then pick the next stall value
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i == 1'b0) check_result(out_word_o);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 20);
      end
    end
  end

  // Parse from reset with no first-byte mark
  task automatic test_unmarked_start();
    put_riff();
    put_fmt(32'd16, 16, $urandom, $urandom, $urandom);
    put_word(ID_DATA);
    put_word($urandom);
  endtask

  // All-ones and all-zeros format fields, bytes after the result dropped
  task automatic test_format_extremes();
    mark_pending = 1'b1;
    put_fmt(32'd16, 16, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
    put_word(ID_DATA);
    put_word(32'hFFFF_FFFF);
    repeat (3) put_byte(8'hFF);
    mark_pending = 1'b1;
    put_fmt(32'd16, 16, 32'h0, 32'h0, 32'h0);
    put_word(ID_DATA);
    put_word(32'h0);
  endtask

  task automatic test_error_paths();
    // Unknown id, then an ignored byte
    mark_pending = 1'b1;
    put_word(ID_LIST);
    put_byte(8'($urandom));
    // Data chunk with no fmt seen
    mark_pending = 1'b1;
    put_riff();
    put_word(ID_DATA);
    put_word($urandom);
    // fmt one byte short, and empty
    mark_pending = 1'b1;
    put_fmt(32'd15, 0, 0, 0, 0);
    mark_pending = 1'b1;
    put_fmt(32'd0, 0, 0, 0, 0);
    // Huge fmt and a partial body, both abandoned by a restart
    mark_pending = 1'b1;
    put_fmt(32'hFFFF_FFFF, 5, $urandom, $urandom, $urandom);
    mark_pending = 1'b1;
    put_fmt(32'd20, 10, $urandom, $urandom, $urandom);
    // Later fmt overwrites an earlier one
    mark_pending = 1'b1;
    put_fmt(32'd16, 16, $urandom, $urandom, $urandom);
    put_fmt(32'd18, 18, $urandom, $urandom, $urandom);
    put_word(ID_DATA);
    put_word($urandom);
  endtask

  // Hold off the output while short error files keep coming
  task automatic test_output_backpressure();
    hold_left = HOLD_CYCLES;
    repeat (24) begin
      mark_pending = 1'b1;
      put_word({24'($urandom_range(24'hFF_FFFF)), 8'h00});
    end
  endtask

  task automatic send_random_file();
    int          kind;
    logic [31:0] sz;
    mark_pending = 1'b1;
    kind         = $urandom_range(99);
    if (kind < 75) begin
      if ($urandom_range(9) < 7) put_riff();
      repeat (($urandom_range(9) == 0) ? 2 : 1) begin
        sz = ($urandom_range(9) != 0) ? $urandom_range(16, 40) : $urandom_range(41, 300);
        put_fmt(sz, sz, $urandom, $urandom, $urandom);
      end
      put_word(ID_DATA);
      put_word($urandom);
      repeat ($urandom_range(0, 6)) put_byte(8'($urandom));
    end else if (kind < 80) begin
      if ($urandom_range(1)) put_fmt(32'd16, 16, $urandom, $urandom, $urandom);
      put_word($urandom);
    end else if (kind < 85) begin
      if ($urandom_range(1)) put_riff();
      put_word(ID_DATA);
      put_word($urandom);
    end else if (kind < 90) begin
      put_fmt($urandom_range(0, 15), 0, 0, 0, 0);
    end else if (kind < 95) begin
      sz = $urandom_range(16, 40);
      put_fmt(sz, $urandom_range(0, sz - 1), $urandom, $urandom, $urandom);
    end else if (kind < 97) begin
      put_fmt($urandom, $urandom_range(0, 20), $urandom, $urandom, $urandom);
    end else begin
      repeat ($urandom_range(1, 12)) begin
        mark_pending = 1'($urandom_range(1));
        put_byte(8'($urandom));
      end
    end
  endtask

  task automatic test_random_files();
    int files;
    files = 0;
    while (bytes_sent < TOTAL_BYTES) begin
      calm = (files >= 8 && files < 20);
      send_random_file();
      files++;
    end
    calm = 1'b0;
  endtask

  // Stop the run at a generous cycle count
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_wav_header_chunk_parser_top: errors");
    $finish;
  end

  initial begin
    clear_parse();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unmarked_start();
    test_format_extremes();
    test_error_paths();
    wait_results_drained();
    test_output_backpressure();
    wait_results_drained();
    test_random_files();
    wait_results_drained();
    if (header_results_q.size() != 0) begin
      $display("%0t: expected %0d more result words, got none", $time,
               header_results_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_wav_header_chunk_parser_top: clean");
    end else begin
      $display("tb_wav_header_chunk_parser_top: errors");
    end
    $finish;
  end

endmodule
